@@ hw/rtl/slc_pkg.sv @@
// Shared types and constants of the S-record line checker.
package slc_pkg;

  // Characters beyond this position in a line are ignored until the newline.
  localparam int unsigned MaxLineChars = 255;
  // Default depth of the internal queues.
  localparam int unsigned QueueDepth   = 2;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharUpperS  = 8'h53;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharOne     = 8'h31;
  localparam logic [7:0] CharTwo     = 8'h32;
  localparam logic [7:0] CharThree   = 8'h33;
  localparam logic [7:0] CharFour    = 8'h34;
  localparam logic [7:0] CharFive    = 8'h35;
  localparam logic [7:0] CharSix     = 8'h36;
  localparam logic [7:0] CharNine    = 8'h39;

  // Address mode codes.
  localparam logic [1:0] ModeS1 = 2'd0;
  localparam logic [1:0] ModeS2 = 2'd1;

  // Input command codes.
  localparam logic CmdChar = 1'b0;
  localparam logic CmdEof  = 1'b1;

  // Report kinds.
  localparam logic ReportLine = 1'b0;
  localparam logic ReportEof  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic        report_kind;
    logic [15:0] line_number;
    logic        type_error;
    logic        checksum_error;
    logic        bytecount_error;
    logic        count_error;
  } result_t;

  // Classified character handed from the front to the back.
  typedef struct packed {
    logic       eof;
    logic       newline;
    logic       space;
    logic       is_s;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       type_ok;    // digit other than '4'
    logic       count_rec;  // '5' or '6'
    logic [2:0] data_sel;   // one-hot '1', '2', '3'
  } tok_t;

endpackage

@@ hw/rtl/slc_fifo.sv @@
// Small flop-based first-in first-out queue.
module slc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/slc_front.sv @@
// Front end: accepts input transactions, classifies characters and queues tokens.
module slc_front #(
  parameter int unsigned Depth = slc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  slc_pkg::in_item_t item_i,
  output logic              tok_valid_o,
  output slc_pkg::tok_t     tok_o,
  input  logic              tok_pop_i
);

  slc_pkg::tok_t          tok;
  logic [7:0]             c;
  logic                   tok_empty;
  logic [$bits(slc_pkg::tok_t)-1:0] tok_raw;

  assign c = item_i.char_code;

  always_comb begin
    tok         = '0;
    tok.eof     = (item_i.command == slc_pkg::CmdEof);
    tok.newline = (item_i.command == slc_pkg::CmdChar) && (c == slc_pkg::CharNewline);
    tok.space   = (c == slc_pkg::CharSpace);
    tok.is_s    = (c == slc_pkg::CharUpperS);
    if (c >= slc_pkg::CharZero && c <= slc_pkg::CharNine) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = 4'(c - slc_pkg::CharZero);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = 4'(c - 8'h57);
    end
    tok.type_ok   = (c >= slc_pkg::CharZero) && (c <= slc_pkg::CharNine)
                    && (c != slc_pkg::CharFour);
    tok.count_rec = (c == slc_pkg::CharFive) || (c == slc_pkg::CharSix);
    tok.data_sel  = {c == slc_pkg::CharThree, c == slc_pkg::CharTwo,
                     c == slc_pkg::CharOne};
  end

  slc_fifo #(
    .Width ($bits(slc_pkg::tok_t)),
    .Depth (Depth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok),
    .full_o  (full),
    .pop_i   (tok_pop_i),
    .data_o  (tok_raw),
    .empty_o (tok_empty)
  );

  assign tok_valid_o = !tok_empty;
  assign tok_o       = slc_pkg::tok_t'(tok_raw);

endmodule

@@ hw/rtl/slc_back.sv @@
// Back end: per-line check state, file counters and the result queue.
module slc_back #(
  parameter int unsigned Depth = slc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       mode_i,
  input  logic             tok_valid_i,
  input  slc_pkg::tok_t    tok_i,
  output logic             tok_pop_o,
  output logic             empty,
  input  logic             pop,
  output slc_pkg::result_t result_o
);

  logic [7:0]  pos_q, pos_d;
  logic        first_s_q, first_s_d;
  logic        rt_ok_q, rt_ok_d;
  logic        rt_cnt_q, rt_cnt_d;
  logic [2:0]  rt_data_q, rt_data_d;
  logic [7:0]  sum_q, sum_d;
  logic [4:0]  hi_q, hi_d;
  logic [7:0]  cfield_q, cfield_d;
  logic [7:0]  payload_q, payload_d;
  logic        space_q, space_d;
  logic [31:0] shift_q, shift_d;
  logic        digits_ok_q, digits_ok_d;
  logic [15:0] line_cnt_q, line_cnt_d;
  logic [31:0] data_cnt_q, data_cnt_d;
  logic [31:0] rec_q, rec_d;

  logic             out_full, res_push, step;
  slc_pkg::result_t res;
  logic [$bits(slc_pkg::result_t)-1:0] res_raw;

  logic        line_open, is_data;
  logic [15:0] line_cls;
  logic [31:0] data_cls, rec_cls;
  logic [7:0]  digit_end, pair_val;

  assign step      = tok_valid_i && !out_full;
  assign tok_pop_o = step;
  assign line_open = (pos_q != '0);

  always_comb begin
    case (mode_i)
      slc_pkg::ModeS1: is_data = rt_data_q[0];
      slc_pkg::ModeS2: is_data = rt_data_q[1];
      default:         is_data = rt_data_q[2];
    endcase
    case (mode_i)
      slc_pkg::ModeS1: digit_end = 8'd8;
      slc_pkg::ModeS2: digit_end = 8'd10;
      default:         digit_end = 8'd12;
    endcase
    // File counters as they stand once the open line is closed.
    line_cls = line_cnt_q;
    data_cls = data_cnt_q;
    rec_cls  = rec_q;
    if (line_open) begin
      if (line_cnt_q != '1) line_cls = line_cnt_q + 1'b1;
      if (is_data && data_cnt_q != '1) data_cls = data_cnt_q + 1'b1;
      if (rt_cnt_q) rec_cls = shift_q;
    end
    if (!hi_q[4]) begin
      pair_val = '0;
    end else if (tok_i.hex_ok) begin
      pair_val = {hi_q[3:0], tok_i.hex_val};
    end else begin
      pair_val = {4'b0, hi_q[3:0]};
    end
  end

  always_comb begin
    pos_d       = pos_q;
    first_s_d   = first_s_q;
    rt_ok_d     = rt_ok_q;
    rt_cnt_d    = rt_cnt_q;
    rt_data_d   = rt_data_q;
    sum_d       = sum_q;
    hi_d        = hi_q;
    cfield_d    = cfield_q;
    payload_d   = payload_q;
    space_d     = space_q;
    shift_d     = shift_q;
    digits_ok_d = digits_ok_q;
    line_cnt_d  = line_cnt_q;
    data_cnt_d  = data_cnt_q;
    rec_d       = rec_q;
    res_push    = 1'b0;

    res                 = '0;
    res.line_number     = line_cls;
    res.type_error      = !(first_s_q && rt_ok_q);
    res.checksum_error  = (sum_q != 8'hFF);
    res.bytecount_error = space_q || ({1'b0, payload_q} != {cfield_q, 1'b0});

    if (step) begin
      if (tok_i.eof || (tok_i.newline && line_open)) begin
        res_push = 1'b1;
        // Clear the line state.
        pos_d       = '0;
        first_s_d   = 1'b0;
        rt_ok_d     = 1'b0;
        rt_cnt_d    = 1'b0;
        rt_data_d   = '0;
        sum_d       = '0;
        hi_d        = '0;
        cfield_d    = '0;
        payload_d   = '0;
        space_d     = 1'b0;
        shift_d     = '0;
        digits_ok_d = 1'b1;
        if (tok_i.eof) begin
          res                 = '0;
          res.report_kind     = slc_pkg::ReportEof;
          res.line_number     = line_cls;
          res.count_error     = (data_cls != rec_cls);
          line_cnt_d          = '0;
          data_cnt_d          = '0;
          rec_d               = '0;
        end else begin
          res.report_kind = slc_pkg::ReportLine;
          line_cnt_d      = line_cls;
          data_cnt_d      = data_cls;
          rec_d           = rec_cls;
        end
      end else if (!tok_i.newline && pos_q < 8'(slc_pkg::MaxLineChars)) begin
        if (pos_q == 8'd0) first_s_d = tok_i.is_s;
        if (pos_q == 8'd1) begin
          rt_ok_d   = tok_i.type_ok;
          rt_cnt_d  = tok_i.count_rec;
          rt_data_d = tok_i.data_sel;
        end
        if (pos_q >= 8'd2) begin
          if (!pos_q[0]) begin
            hi_d = {tok_i.hex_ok, tok_i.hex_val};
          end else begin
            sum_d = sum_q + pair_val;
            if (pos_q == 8'd3) cfield_d = pair_val;
            hi_d = '0;
          end
        end
        if (pos_q >= 8'd4) begin
          if (payload_q != '1) payload_d = payload_q + 1'b1;
          if (tok_i.space) space_d = 1'b1;
          if (pos_q < digit_end && digits_ok_q) begin
            if (tok_i.hex_ok) begin
              shift_d = {shift_q[27:0], tok_i.hex_val};
            end else begin
              digits_ok_d = 1'b0;
            end
          end
        end
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_s_q   <= 1'b0;
      rt_ok_q     <= 1'b0;
      rt_cnt_q    <= 1'b0;
      rt_data_q   <= '0;
      sum_q       <= '0;
      hi_q        <= '0;
      cfield_q    <= '0;
      payload_q   <= '0;
      space_q     <= 1'b0;
      shift_q     <= '0;
      digits_ok_q <= 1'b1;
      line_cnt_q  <= '0;
      data_cnt_q  <= '0;
      rec_q       <= '0;
    end else begin
      pos_q       <= pos_d;
      first_s_q   <= first_s_d;
      rt_ok_q     <= rt_ok_d;
      rt_cnt_q    <= rt_cnt_d;
      rt_data_q   <= rt_data_d;
      sum_q       <= sum_d;
      hi_q        <= hi_d;
      cfield_q    <= cfield_d;
      payload_q   <= payload_d;
      space_q     <= space_d;
      shift_q     <= shift_d;
      digits_ok_q <= digits_ok_d;
      line_cnt_q  <= line_cnt_d;
      data_cnt_q  <= data_cnt_d;
      rec_q       <= rec_d;
    end
  end

  slc_fifo #(
    .Width ($bits(slc_pkg::result_t)),
    .Depth (Depth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign result_o = slc_pkg::result_t'(res_raw);

endmodule

@@ hw/rtl/srecord_line_checker.sv @@
// Top level of the S-record line checker: address mode register, front and back ends.
//
//  channel   direction  handshake             payload
//  --------  ---------  --------------------  -------------------------------------
//  input     in         push / full           item_i   (command, char_code)
//  result    out        pop / empty           result_o (report_kind .. count_error)
//  config    in         cfg_we_i (no wait)    cfg_wdata_i (address_mode)
//
// One character per cycle sustained while the result queue has room: the back end
// updates the line state for one token per cycle and stalls while that queue is full.
// A line or end-of-file report passes through the token queue into the result
// queue, where it can be popped.
// Reset is asynchronous and active low and needs no clearing pass; the block
// takes input from the first cycle after reset.
// full rises only when the token queue fills because results are not popped;
// a full result queue stalls the back end and, in turn, the input side.
module srecord_line_checker #(
  parameter int unsigned QueueDepth = slc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input queue side
  input  logic              push,
  output logic              full,
  input  slc_pkg::in_item_t item_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output slc_pkg::result_t  result_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i
);

  logic [1:0]    addr_mode_q;
  logic          tok_valid, tok_pop;
  slc_pkg::tok_t tok;

  // Address mode register; codes two and three both behave like S3 in the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_mode_q <= slc_pkg::ModeS1;
    end else if (cfg_we_i) begin
      addr_mode_q <= cfg_wdata_i;
    end
  end

  // Front: accept a transaction, classify the character, queue the token.
  slc_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  // Back: advance line state, close lines, emit reports into the result queue.
  slc_back #(
    .Depth (QueueDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (addr_mode_q),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule
